[rtl/fra_pkg.sv]
// Shared types and constants for the four-register ALU executor.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package fra_pkg;

	// Default geometry of the register file
	localparam int REG_COUNT_DEF  = 4;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed field widths of the command and response beats
	localparam int MODE_W    = 3;
	localparam int REG_IDX_W = 2;
	localparam int IMM_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int VALUE_W   = 32;

	// Operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_MOV = 3'd0,
		MODE_ADD = 3'd1,
		MODE_SUB = 3'd2,
		MODE_MUL = 3'd3,
		MODE_DIV = 3'd4,
		MODE_INC = 3'd5,
		MODE_DEC = 3'd6,
		MODE_END = 3'd7
	} mode_t;

	// Response status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_DIVZERO = 2'd1,
		ST_ENDED   = 2'd2,
		ST_HALTED  = 2'd3
	} status_t;

	// Sequencer to arithmetic unit
	typedef struct packed {
		logic  start;
		mode_t op;
	} alu_req_t;

	// Arithmetic unit back to sequencer
	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_rsp_t;

endpackage

`default_nettype wire

[rtl/fra_regfile.sv]
// Register file of the ALU executor: one read port, one write port.
// Depends on fra_pkg; indexes at or beyond REG_COUNT read zero and drop writes.
`default_nettype none

module fra_regfile import fra_pkg::*; #(
	parameter int REG_COUNT  = REG_COUNT_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [REG_IDX_W-1:0]  rd_idx,
	output logic [DATA_WIDTH-1:0] rd_data,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_idx,
	input  logic [DATA_WIDTH-1:0] wr_data
);

	localparam int IW = $clog2(REG_COUNT);

	logic [DATA_WIDTH-1:0] regs_q [REG_COUNT];
	logic [IW-1:0]         rd_sel;
	logic [IW-1:0]         wr_sel;
	logic                  rd_hit;
	logic                  wr_hit;

	// Decode indexes and range checks
	always_comb begin
		rd_sel = IW'(rd_idx);
		wr_sel = IW'(wr_idx);
		rd_hit = (32'(rd_idx) < REG_COUNT);
		wr_hit = (32'(wr_idx) < REG_COUNT);
	end

	// Read the addressed register, zero when out of range
	assign rd_data = rd_hit ? regs_q[rd_sel] : '0;

	// Write the addressed register, drop when out of range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{default: '0};
		end else if (wr_en && wr_hit) begin
			regs_q[wr_sel] <= wr_data;
		end
	end

endmodule

`default_nettype wire

[rtl/fra_alu_seq.sv]
// Shared adder/subtractor with a small sequencer: single-pass add ops,
// shift-add multiply and restoring signed divide. Depends on fra_pkg.
`default_nettype none

module fra_alu_seq import fra_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alu_req_t              req,
	input  logic [DATA_WIDTH-1:0] opa,
	input  logic [DATA_WIDTH-1:0] opb,
	output alu_rsp_t              rsp,
	output logic [DATA_WIDTH-1:0] res
);

	localparam int                   W1     = DATA_WIDTH + 1;
	localparam int                   CW     = $clog2(DATA_WIDTH);
	localparam logic [CW-1:0]        LAST   = CW'(DATA_WIDTH - 1);
	localparam logic [DATA_WIDTH-1:0] ONE_V = DATA_WIDTH'(1);

	typedef enum logic [5:0] {
		U_IDLE = 6'b000001,
		U_ONE  = 6'b000010,
		U_NEGA = 6'b000100,
		U_NEGB = 6'b001000,
		U_LOOP = 6'b010000,
		U_NEGQ = 6'b100000
	} unit_state_t;

	unit_state_t           state_q;
	mode_t                 op_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] opd_q;
	logic [DATA_WIDTH-1:0] shr_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic                  done_q;
	logic                  dz_q;

	logic [DATA_WIDTH-1:0] add_x;
	logic [DATA_WIDTH-1:0] add_y;
	logic                  add_sub;
	logic [W1-1:0]         sum;
	logic [DATA_WIDTH-1:0] rem_sh;
	logic                  is_div;

	assign is_div = (op_q == MODE_DIV);
	assign rem_sh = {acc_q[DATA_WIDTH-2:0], shr_q[DATA_WIDTH-1]};

	// Select adder operands for the current step
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			U_ONE: begin
				unique case (op_q)
					MODE_MOV: add_y = opd_q;
					MODE_ADD: begin
						add_x = acc_q;
						add_y = opd_q;
					end
					MODE_SUB: begin
						add_x   = acc_q;
						add_y   = opd_q;
						add_sub = 1'b1;
					end
					MODE_INC: begin
						add_x = acc_q;
						add_y = ONE_V;
					end
					MODE_DEC: begin
						add_x   = acc_q;
						add_y   = ONE_V;
						add_sub = 1'b1;
					end
					default: add_x = acc_q;
				endcase
			end
			U_NEGA, U_NEGQ: begin
				add_y   = shr_q;
				add_sub = 1'b1;
			end
			U_NEGB: begin
				add_y   = opd_q;
				add_sub = 1'b1;
			end
			U_LOOP: begin
				if (is_div) begin
					add_x   = rem_sh;
					add_y   = opd_q;
					add_sub = 1'b1;
				end else begin
					add_x = acc_q;
					add_y = shr_q[0] ? opd_q : '0;
				end
			end
			default: add_x = '0;
		endcase
	end

	// Shared adder; carry out high on subtract means no borrow
	assign sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_WIDTH{add_sub}}} + W1'(add_sub);

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
			dz_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			dz_q   <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						cnt_q <= LAST;
						if (req.op == MODE_DIV) begin
							if (opb == '0) begin
								done_q <= 1'b1;
								dz_q   <= 1'b1;
							end else begin
								state_q <= U_NEGA;
							end
						end else if (req.op == MODE_MUL) begin
							state_q <= U_LOOP;
						end else begin
							state_q <= U_ONE;
						end
					end
				end
				U_ONE: begin
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				U_NEGA: state_q <= U_NEGB;
				U_NEGB: state_q <= U_LOOP;
				U_LOOP: begin
					if (cnt_q == '0) begin
						if (is_div) begin
							state_q <= U_NEGQ;
						end else begin
							done_q  <= 1'b1;
							state_q <= U_IDLE;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_NEGQ: begin
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	// Hold operands, partial results and the final value
	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					neg_q <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
					if (req.op == MODE_DIV) begin
						acc_q <= '0;
						shr_q <= opa;
						opd_q <= opb;
					end else if (req.op == MODE_MUL) begin
						acc_q <= '0;
						opd_q <= opa;
						shr_q <= opb;
					end else begin
						acc_q <= opa;
						opd_q <= opb;
					end
				end
			end
			U_ONE: res_q <= sum[DATA_WIDTH-1:0];
			U_NEGA: begin
				if (shr_q[DATA_WIDTH-1]) begin
					shr_q <= sum[DATA_WIDTH-1:0];
				end
			end
			U_NEGB: begin
				if (opd_q[DATA_WIDTH-1]) begin
					opd_q <= sum[DATA_WIDTH-1:0];
				end
			end
			U_LOOP: begin
				if (is_div) begin
					acc_q <= sum[DATA_WIDTH] ? sum[DATA_WIDTH-1:0] : rem_sh;
					shr_q <= {shr_q[DATA_WIDTH-2:0], sum[DATA_WIDTH]};
				end else begin
					acc_q <= sum[DATA_WIDTH-1:0];
					opd_q <= {opd_q[DATA_WIDTH-2:0], 1'b0};
					shr_q <= {1'b0, shr_q[DATA_WIDTH-1:1]};
					if (cnt_q == '0) begin
						res_q <= sum[DATA_WIDTH-1:0];
					end
				end
			end
			U_NEGQ: res_q <= neg_q ? sum[DATA_WIDTH-1:0] : shr_q;
			default: res_q <= res_q;
		endcase
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign res          = res_q;

endmodule

`default_nettype wire

[rtl/four_register_alu_executor.sv]
// Four-register ALU executor, top level: command sequencer and response register.
// MUL and DIV run through the shared adder one bit per cycle.
// One command at a time, taken the cycle after the response loads.
// Reset clears all registers to zero and the halted flag; only reset leaves halt.
`default_nettype none

module four_register_alu_executor import fra_pkg::*; #(
	parameter int REG_COUNT  = REG_COUNT_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic [MODE_W-1:0]          mode,
	input  logic [REG_IDX_W-1:0]       dest_reg,
	input  logic                       src_is_reg,
	input  logic [REG_IDX_W-1:0]       src_reg,
	input  logic signed [IMM_W-1:0]    immediate,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [REG_IDX_W-1:0]       written_reg,
	output logic signed [VALUE_W-1:0]  new_value
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_RDA    = 5'b00010,
		S_RDB    = 5'b00100,
		S_EXEC   = 5'b01000,
		S_RDBACK = 5'b10000
	} top_state_t;

	top_state_t               state_q;
	logic                     halted_q;
	logic                     rsp_valid_q;
	mode_t                    mode_q;
	logic [REG_IDX_W-1:0]     dest_q;
	logic                     sis_q;
	logic [REG_IDX_W-1:0]     sreg_q;
	logic [DATA_WIDTH-1:0]    imm_q;
	logic [DATA_WIDTH-1:0]    a_q;
	status_t                  sts_q;
	status_t                  status_q;
	logic [REG_IDX_W-1:0]     written_q;
	logic signed [VALUE_W-1:0] value_q;

	logic                     cmd_fire;
	logic                     out_free;
	logic [REG_IDX_W-1:0]     rf_rd_idx;
	logic [DATA_WIDTH-1:0]    rf_rd_data;
	logic                     rf_we;
	logic [DATA_WIDTH-1:0]    b_val;
	alu_req_t                 alu_req;
	alu_rsp_t                 alu_rsp;
	logic [DATA_WIDTH-1:0]    alu_res;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Steer the read port, pick the source operand, kick the unit
	always_comb begin
		rf_rd_idx     = (state_q == S_RDB) ? sreg_q : dest_q;
		b_val         = sis_q ? rf_rd_data : imm_q;
		alu_req.start = (state_q == S_RDB) && (mode_q != MODE_END);
		alu_req.op    = mode_q;
		rf_we         = (state_q == S_EXEC) && alu_rsp.done && !alu_rsp.div_zero;
	end

	fra_regfile #(
		.REG_COUNT  (REG_COUNT),
		.DATA_WIDTH (DATA_WIDTH)
	) u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rf_rd_idx),
		.rd_data (rf_rd_data),
		.wr_en   (rf_we),
		.wr_idx  (dest_q),
		.wr_data (alu_res)
	);

	fra_alu_seq #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (a_q),
		.opb    (b_val),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

	// Advance the command sequencer, track halt and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			halted_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RDBACK && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						state_q <= S_RDA;
					end
				end
				S_RDA: state_q <= halted_q ? S_RDBACK : S_RDB;
				S_RDB: begin
					if (mode_q == MODE_END) begin
						halted_q <= 1'b1;
						state_q  <= S_RDBACK;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (alu_rsp.done) begin
						if (alu_rsp.div_zero) begin
							halted_q <= 1'b1;
						end
						state_q <= S_RDBACK;
					end
				end
				S_RDBACK: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the command beat, operands, pending status and the response beat
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			mode_q <= mode_t'(mode);
			dest_q <= dest_reg;
			sis_q  <= src_is_reg;
			sreg_q <= src_reg;
			imm_q  <= DATA_WIDTH'(immediate);
		end
		if (state_q == S_RDA) begin
			a_q   <= rf_rd_data;
			sts_q <= halted_q ? ST_HALTED : ST_OK;
		end
		if (state_q == S_RDB && mode_q == MODE_END) begin
			sts_q <= ST_ENDED;
		end
		if (state_q == S_EXEC && alu_rsp.done && alu_rsp.div_zero) begin
			sts_q <= ST_DIVZERO;
		end
		if (state_q == S_RDBACK && out_free) begin
			status_q  <= sts_q;
			written_q <= dest_q;
			value_q   <= signed'(VALUE_W'(rf_rd_data));
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign written_reg = written_q;
	assign new_value   = value_q;

	// No register write once halted
	a_no_write_halted: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> !halted_q)
		else $error("register write while halted");

	// A divide-by-zero or END response implies the halt flag is set
	a_halt_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_DIVZERO || status == ST_ENDED) |-> halted_q)
		else $error("halting status without halt flag");

	// The unit only finishes while the sequencer waits for it
	a_done_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_EXEC)
		else $error("arithmetic unit done outside execute state");

	// Halt is sticky until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for four_register_alu_executor: directed and random instruction beats,
// checked against a register-file predictor kept in a small scoreboard class.
// Depends on rtl/fra_pkg.sv and rtl/four_register_alu_executor.sv.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fra_pkg::*;

	localparam int RANDOM_ITEMS = 1250;
	localparam int CALM_ITEMS   = 200;
	localparam int HALTED_ITEMS = 30;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 600000;

	localparam logic [IMM_W-1:0] IMM_MIN = {1'b1, {(IMM_W-1){1'b0}}};
	localparam logic [IMM_W-1:0] IMM_MAX = {1'b0, {(IMM_W-1){1'b1}}};

	typedef enum logic [REG_IDX_W-1:0] {
		R_EAX = 2'd0,
		R_EBX = 2'd1,
		R_ECX = 2'd2,
		R_EDX = 2'd3
	} reg_id_t;

	typedef struct {
		mode_t                op;
		logic [REG_IDX_W-1:0] dest;
		logic                 src_is_reg;
		logic [REG_IDX_W-1:0] src;
		logic [IMM_W-1:0]     imm;
	} instr_t;

	typedef struct {
		status_t              st;
		logic [REG_IDX_W-1:0] dest;
		logic [VALUE_W-1:0]   value;
	} outcome_t;

	// Register file predictor and queue of outcomes still owed by the block
	class reg_file_model;
		logic [VALUE_W-1:0] regs [REG_COUNT_DEF];
		bit                 halted;
		int                 errors;
		outcome_t           owed[$];

		function new();
			foreach (regs[i]) regs[i] = '0;
			halted = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function logic [VALUE_W-1:0] operand(instr_t c);
			return c.src_is_reg ? regs[c.src] : c.imm;
		endfunction

		// Signed divide, truncating toward zero; minimum by minus one wraps
		function logic [VALUE_W-1:0] quotient(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
			logic [VALUE_W-1:0] ma, mb, q;
			ma = a[VALUE_W-1] ? -a : a;
			mb = b[VALUE_W-1] ? -b : b;
			q = ma / mb;
			if (a[VALUE_W-1] ^ b[VALUE_W-1])
				q = -q;
			return q;
		endfunction

		function void note_command(instr_t c);
			logic [VALUE_W-1:0] a, b, r;
			outcome_t o;
			a = regs[c.dest];
			b = operand(c);
			r = a;
			o.st = ST_OK;
			if (halted) begin
				o.st = ST_HALTED;
			end else begin
				case (c.op)
					MODE_MOV: r = b;
					MODE_ADD: r = a + b;
					MODE_SUB: r = a - b;
					MODE_MUL: r = a * b;
					MODE_DIV: begin
						if (b == '0) begin
							o.st = ST_DIVZERO;
							halted = 1'b1;
						end else begin
							r = quotient(a, b);
						end
					end
					MODE_INC: r = a + 1'b1;
					MODE_DEC: r = a - 1'b1;
					default: begin
						o.st = ST_ENDED;
						halted = 1'b1;
					end
				endcase
				if (o.st == ST_OK)
					regs[c.dest] = r;
			end
			o.dest = c.dest;
			o.value = regs[c.dest];
			owed.push_back(o);
		endfunction

		function void check_response(logic [STATUS_W-1:0] st, logic [REG_IDX_W-1:0] dest,
				logic [VALUE_W-1:0] value);
			outcome_t o;
			if (owed.size() == 0) begin
				$display("%0t: response beat with none expected: status %0d reg %0d value %0d",
					$time, st, dest, $signed(value));
				errors++;
				return;
			end
			o = owed.pop_front();
			if (st !== o.st) begin
				$display("%0t: status expected %0d actual %0d", $time, o.st, st);
				errors++;
			end
			if (dest !== o.dest) begin
				$display("%0t: written_reg expected %0d actual %0d", $time, o.dest, dest);
				errors++;
			end
			if (value !== o.value) begin
				$display("%0t: new_value expected %0d actual %0d", $time,
					$signed(o.value), $signed(value));
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cmd_valid;
	logic                        cmd_stall;
	logic [MODE_W-1:0]           mode;
	logic [REG_IDX_W-1:0]        dest_reg;
	logic                        src_is_reg;
	logic [REG_IDX_W-1:0]        src_reg;
	logic signed [IMM_W-1:0]     immediate;
	logic                        rsp_valid;
	logic                        rsp_stall;
	logic [STATUS_W-1:0]         status;
	logic [REG_IDX_W-1:0]        written_reg;
	logic signed [VALUE_W-1:0]   new_value;

	reg_file_model sb;
	bit            calm;
	int            cycles;

	four_register_alu_executor u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.mode        (mode),
		.dest_reg    (dest_reg),
		.src_is_reg  (src_is_reg),
		.src_reg     (src_reg),
		.immediate   (immediate),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.written_reg (written_reg),
		.new_value   (new_value)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Check every accepted response beat
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(status, written_reg, new_value);
	end

	// Stall the response side in random bursts, with calm stretches between
	initial begin : rsp_stall_gen
		int n;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 19);
				rsp_stall <= 1'b1;
				repeat (n) @(negedge clk);
				rsp_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				n = $urandom_range(40, 150);
				rsp_stall <= 1'b0;
				repeat (n) @(negedge clk);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic instr_t make_instr(mode_t op, reg_id_t dest, logic sis, reg_id_t src,
			logic [IMM_W-1:0] imm);
		instr_t c;
		c.op = op;
		c.dest = dest;
		c.src_is_reg = sis;
		c.src = src;
		c.imm = imm;
		return c;
	endfunction

	// Bias immediates toward the corners of the signed range
	function automatic logic [IMM_W-1:0] pick_imm();
		logic [IMM_W-1:0] corners [8];
		corners = '{'0, 32'd1, '1, IMM_MIN, IMM_MAX, IMM_MIN + 1'b1, IMM_MAX - 1'b1, 32'd2};
		case ($urandom_range(0, 3))
			0: return corners[$urandom_range(0, 7)];
			1: return IMM_W'(int'($urandom_range(0, 64)) - 32);
			default: return $urandom;
		endcase
	endfunction

	// Random instruction that keeps the block running: no END, no zero divisor
	function automatic instr_t running_instr();
		instr_t c;
		c.op = mode_t'($urandom_range(0, 6));
		c.dest = REG_IDX_W'($urandom_range(0, 3));
		c.src_is_reg = 1'($urandom_range(0, 1));
		c.src = REG_IDX_W'($urandom_range(0, 3));
		c.imm = pick_imm();
		if (c.op == MODE_DIV && sb.operand(c) == '0) begin
			c.src_is_reg = 1'b0;
			c.imm = $urandom_range(0, 1) ? IMM_W'(1 + $urandom_range(0, 20)) : ~IMM_W'(0) << 1;
			if (c.imm == '0)
				c.imm = '1;
		end
		return c;
	endfunction

	// Present one instruction beat and hold it until accepted
	task automatic send_instr(instr_t c);
		int n;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 19);
			cmd_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		mode       <= c.op;
		dest_reg   <= c.dest;
		src_is_reg <= c.src_is_reg;
		src_reg    <= c.src;
		immediate  <= c.imm;
		cmd_valid  <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		sb.note_command(c);
	endtask

	initial begin : main
		instr_t c;
		instr_t directed[$];
		reg_id_t zero_reg;
		bit found;

		sb = new();
		calm = 1'b0;
		cycles = 0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		mode = MODE_MOV;
		dest_reg = '0;
		src_is_reg = 1'b0;
		src_reg = '0;
		immediate = '0;

		// Hold reset, then release it on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, wraps, every running operation
		directed.push_back(make_instr(MODE_MOV, R_EAX, 1'b0, R_EDX, IMM_MAX));
		directed.push_back(make_instr(MODE_MOV, R_EBX, 1'b0, R_ECX, IMM_MIN));
		directed.push_back(make_instr(MODE_ADD, R_EAX, 1'b0, R_EAX, 32'd1));
		directed.push_back(make_instr(MODE_SUB, R_EBX, 1'b0, R_EAX, 32'd1));
		directed.push_back(make_instr(MODE_MOV, R_ECX, 1'b1, R_EAX, '0));
		directed.push_back(make_instr(MODE_MUL, R_ECX, 1'b0, R_EAX, '1));
		directed.push_back(make_instr(MODE_ADD, R_ECX, 1'b1, R_ECX, '1));
		directed.push_back(make_instr(MODE_MOV, R_EDX, 1'b0, R_EAX, 32'h1234_5678));
		directed.push_back(make_instr(MODE_MUL, R_EDX, 1'b1, R_EDX, '0));
		directed.push_back(make_instr(MODE_INC, R_EDX, 1'b1, R_EBX, '1));
		directed.push_back(make_instr(MODE_DEC, R_EAX, 1'b0, R_ECX, IMM_MAX));
		directed.push_back(make_instr(MODE_MOV, R_EAX, 1'b0, R_EAX, IMM_MIN));
		directed.push_back(make_instr(MODE_DIV, R_EAX, 1'b0, R_EAX, '1));
		directed.push_back(make_instr(MODE_MOV, R_EBX, 1'b0, R_EAX, -32'sd7));
		directed.push_back(make_instr(MODE_DIV, R_EBX, 1'b0, R_EAX, 32'd2));
		directed.push_back(make_instr(MODE_MOV, R_ECX, 1'b0, R_EAX, 32'd7));
		directed.push_back(make_instr(MODE_DIV, R_ECX, 1'b0, R_EAX, -32'sd2));
		directed.push_back(make_instr(MODE_MOV, R_EDX, 1'b0, R_EAX, IMM_MAX));
		directed.push_back(make_instr(MODE_DIV, R_EDX, 1'b1, R_ECX, '0));
		directed.push_back(make_instr(MODE_SUB, R_EAX, 1'b1, R_EAX, '0));
		directed.push_back(make_instr(MODE_INC, R_EAX, 1'b0, R_EDX, IMM_MIN));
		directed.push_back(make_instr(MODE_DEC, R_EAX, 1'b0, R_EAX, '0));
		directed.push_back(make_instr(MODE_MUL, R_EBX, 1'b0, R_EAX, IMM_MIN));
		foreach (directed[i])
			send_instr(directed[i]);

		// Drain before the random part
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);

		// Random running instructions; no idling in the last stretch
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			send_instr(running_instr());
		end

		// Halt by END or by a zero divisor, chosen per seed
		c = running_instr();
		if ($urandom_range(0, 1)) begin
			c.op = MODE_END;
		end else begin
			c.op = MODE_DIV;
			found = 1'b0;
			zero_reg = R_EAX;
			foreach (sb.regs[i]) begin
				if (!found && sb.regs[i] == '0) begin
					found = 1'b1;
					zero_reg = reg_id_t'(i);
				end
			end
			c.src_is_reg = found;
			c.src = zero_reg;
			c.imm = found ? pick_imm() : '0;
		end
		send_instr(c);

		// Everything after the halt is ignored
		for (int i = 0; i < HALTED_ITEMS; i++) begin
			c = running_instr();
			c.op = mode_t'($urandom_range(0, 7));
			if ($urandom_range(0, 3) == 0)
				c.imm = '0;
			send_instr(c);
		end
		@(negedge clk);
		cmd_valid <= 1'b0;

		// Wait for the last responses, then let the block settle
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
rtl/fra_pkg.sv
rtl/fra_regfile.sv
rtl/fra_alu_seq.sv
rtl/four_register_alu_executor.sv
bench/tb_top.sv
